// File: sv/assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge outside reset.
`define VLPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition is followed by another one on the next edge.
`define VLPT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define VLPT_ASSERT(lbl, clk, rstn, prop, msg)
`define VLPT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// File: sv/vlpt_pkg.sv
package vlpt_pkg;

  // Field and register widths.
  localparam int SAMPLE_W  = 10;
  localparam int LEVEL_W   = 10;
  localparam int HEIGHT_W  = 6;
  localparam int TOP_W     = 7;
  localparam int COLPIX_W  = 6;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int FALL_W    = 8;

  // Divider operand widths: top times a level difference over an average span.
  localparam int NUM_W = TOP_W + LEVEL_W;
  localparam int DEN_W = LEVEL_W;

  localparam int WINDOW_LEN_DEF = 6;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]    DC_OFFSET_RST   = 8'd0;
  localparam logic [CFG_W-1:0]    NOISE_FLOOR_RST = 8'd10;
  localparam logic [CFG_W-1:0]    PEAK_FALL_RST   = 8'd15;
  localparam logic [COLPIX_W-1:0] COLPIX_RST      = 6'd16;

  // Reset values of the tracking state.
  localparam logic [LEVEL_W-1:0] LEVEL_RST   = 10'd2;
  localparam logic [LEVEL_W-1:0] MIN_AVG_RST = 10'd0;
  localparam logic [LEVEL_W-1:0] MAX_AVG_RST = 10'd512;
  localparam logic [TOP_W-1:0]   PEAK_RST    = 7'd6;

  // Converter midpoint, as a 12-bit two's complement operand.
  localparam logic [11:0] SAMPLE_MID = 12'd512;

  // Extra rows above the column that make up the bar top.
  localparam logic [TOP_W-1:0] TOP_EXTRA = 7'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_OFFSET     = 2'd0,
    CFG_NOISE_FLOOR   = 2'd1,
    CFG_PEAK_FALL     = 2'd2,
    CFG_COLUMN_PIXELS = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic setup;
    logic finish;
  } vlpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic out_free;
  } vlpt_sts_t;

endpackage

// File: sv/vlpt_ram.sv
module vlpt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 6
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/vlpt_div.sv
module vlpt_div #(
  parameter int NUM_W = vlpt_pkg::NUM_W,
  parameter int DEN_W = vlpt_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // Step counter and sticky done flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(NUM_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: sv/vlpt_ctrl.sv
module vlpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vlpt_pkg::vlpt_sts_t sts,
  output vlpt_pkg::vlpt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SETUP,
    S_RUN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   finish;

  // A request finishes once the divider and the window scan are both done
  // and the output register can take the result.
  assign finish = (state_r == S_RUN) && sts.div_done && sts.scan_done && sts.out_free;

  always_comb begin
    cmd.load   = in_valid && in_ready_r;
    cmd.prep   = (state_r == S_PREP);
    cmd.setup  = (state_r == S_SETUP);
    cmd.finish = finish;
  end

  // Sequencer state and the registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_PREP;
            in_ready_r <= 1'b0;
          end
        end
        S_PREP: begin
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (finish) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: sv/vlpt_dp.sv
module vlpt_dp #(
  parameter int WINDOW_LEN = vlpt_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [vlpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vlpt_pkg::CFG_W-1:0]           cfg_data,
  input  logic [vlpt_pkg::SAMPLE_W-1:0]        in_mic_sample,
  input  vlpt_pkg::vlpt_cmd_t                  cmd,
  output vlpt_pkg::vlpt_sts_t                  sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [vlpt_pkg::HEIGHT_W-1:0]        out_bar_height,
  output logic [vlpt_pkg::HEIGHT_W-1:0]        out_peak_height,
  output logic                                 out_peak_visible,
  output logic [vlpt_pkg::LEVEL_W-1:0]         out_smoothed_level
);

  localparam int LW  = vlpt_pkg::LEVEL_W;
  localparam int TW  = vlpt_pkg::TOP_W;
  localparam int NW  = vlpt_pkg::NUM_W;
  localparam int AW  = $clog2(WINDOW_LEN);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_LEN - 1);

  // Configuration registers.
  logic [vlpt_pkg::CFG_W-1:0]    dc_off_r;
  logic [vlpt_pkg::CFG_W-1:0]    nfloor_r;
  logic [vlpt_pkg::FALL_W-1:0]   pff_r;
  logic [vlpt_pkg::COLPIX_W-1:0] colpix_r;

  // Tracking state.
  logic [LW-1:0]                 level_r;
  logic [LW-1:0]                 min_avg_r;
  logic [LW-1:0]                 max_avg_r;
  logic [TW-1:0]                 peak_r;
  logic [vlpt_pkg::FALL_W-1:0]   fall_cnt_r;
  logic [AW-1:0]                 win_idx_r;
  logic [WINDOW_LEN-1:0]         win_vld_r;

  // Per-request working registers.
  logic [vlpt_pkg::SAMPLE_W-1:0] mic_r;
  logic                          div_zero_r;
  logic                          res_zero_r;
  logic [LW-1:0]                 lo_r;
  logic [LW-1:0]                 hi_r;

  // Window scan control.
  logic                          scan_act_r;
  logic [AW-1:0]                 scan_addr_r;
  logic                          rd_pend_r;
  logic                          rd_first_r;
  logic                          rd_last_r;
  logic                          rd_vld_r;
  logic                          scan_done_r;
  logic [LW-1:0]                 ram_q;
  logic [LW-1:0]                 scan_val;

  // Output register.
  logic                          out_valid_r;
  logic [vlpt_pkg::HEIGHT_W-1:0] bar_r;
  logic [vlpt_pkg::HEIGHT_W-1:0] peak_out_r;
  logic                          vis_r;
  logic [LW-1:0]                 lvl_out_r;

  logic [TW-1:0]                 top_w;

  // Rectify and smoothing signals.
  logic [11:0]                   centered;
  logic [11:0]                   rect_full;
  logic [LW-1:0]                 rect;
  logic [LW-1:0]                 amp;
  logic [12:0]                   level_sum;
  logic [LW-1:0]                 level_nxt;
  logic [AW-1:0]                 win_idx_nxt;

  // Divider operand signals.
  logic [LW:0]                   lm;
  logic [LW:0]                   lm_neg;
  logic [LW-1:0]                 lm_mag;
  logic [NW-1:0]                 num_mag;
  logic [LW:0]                   dd;
  logic [LW:0]                   dd_neg;
  logic [LW-1:0]                 dd_mag;
  logic [NW-1:0]                 quot;
  logic                          div_done;

  // Finish signals.
  logic [TW-1:0]                 height;
  logic [TW-1:0]                 peak_nxt;
  logic [vlpt_pkg::FALL_W-1:0]   fall_inc;
  logic                          fall_hit;
  logic [LW-1:0]                 span;
  logic [LW:0]                   hi_adj;
  logic [16:0]                   min_sum;
  logic [16:0]                   max_sum;

  assign top_w = {1'b0, colpix_r} + vlpt_pkg::TOP_EXTRA;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_off_r <= vlpt_pkg::DC_OFFSET_RST;
      nfloor_r <= vlpt_pkg::NOISE_FLOOR_RST;
      pff_r    <= vlpt_pkg::PEAK_FALL_RST;
      colpix_r <= vlpt_pkg::COLPIX_RST;
    end else if (cfg_we) begin
      unique case (vlpt_pkg::cfg_idx_t'(cfg_index))
        vlpt_pkg::CFG_DC_OFFSET:     dc_off_r <= cfg_data;
        vlpt_pkg::CFG_NOISE_FLOOR:   nfloor_r <= cfg_data;
        vlpt_pkg::CFG_PEAK_FALL:     pff_r    <= cfg_data;
        vlpt_pkg::CFG_COLUMN_PIXELS: colpix_r <= cfg_data[vlpt_pkg::COLPIX_W-1:0];
        default:                     dc_off_r <= dc_off_r;
      endcase
    end
  end

  // Rectify around the midpoint plus offset, remove the noise floor, smooth.
  always_comb begin
    centered  = {2'b00, mic_r} - vlpt_pkg::SAMPLE_MID - {{4{dc_off_r[7]}}, dc_off_r};
    rect_full = centered[11] ? (12'd0 - centered) : centered;
    rect      = rect_full[LW-1:0];
    amp       = (rect <= {2'b00, nfloor_r}) ? '0 : (rect - {2'b00, nfloor_r});
    level_sum = {level_r, 3'b000} - {3'b000, level_r} + {3'b000, amp};
    level_nxt = level_sum[12:3];
    win_idx_nxt = (win_idx_r == LAST_IDX) ? '0 : (win_idx_r + AW'(1));
  end

  // Divider operands: top times (level - min) over (max - min), as magnitudes.
  always_comb begin
    lm      = {1'b0, level_r} - {1'b0, min_avg_r};
    lm_neg  = (LW+1)'(0) - lm;
    lm_mag  = lm[LW] ? lm_neg[LW-1:0] : lm[LW-1:0];
    num_mag = {{LW{1'b0}}, top_w} * {{TW{1'b0}}, lm_mag};
    dd      = {1'b0, max_avg_r} - {1'b0, min_avg_r};
    dd_neg  = (LW+1)'(0) - dd;
    dd_mag  = dd[LW] ? dd_neg[LW-1:0] : dd[LW-1:0];
  end

  vlpt_div #(
    .NUM_W (NW),
    .DEN_W (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.setup),
    .dividend (num_mag),
    .divisor  (dd_mag),
    .quotient (quot),
    .done     (div_done)
  );

  // Window of recent amplitudes; entries not yet written read as zero.
  vlpt_ram #(
    .WIDTH (LW),
    .DEPTH (WINDOW_LEN)
  ) u_win (
    .clk   (clk),
    .we    (cmd.prep),
    .waddr (win_idx_r),
    .wdata (amp),
    .raddr (scan_addr_r),
    .rdata (ram_q)
  );

  assign scan_val = rd_vld_r ? ram_q : '0;

  // Scan control: one read per cycle, data follows in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r  <= 1'b0;
      scan_addr_r <= '0;
      rd_pend_r   <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      rd_pend_r <= scan_act_r;
      if (cmd.setup) begin
        scan_act_r  <= 1'b1;
        scan_addr_r <= '0;
        scan_done_r <= 1'b0;
      end else begin
        if (scan_act_r) begin
          if (scan_addr_r == LAST_IDX) begin
            scan_act_r <= 1'b0;
          end else begin
            scan_addr_r <= scan_addr_r + AW'(1);
          end
        end
        if (rd_pend_r && rd_last_r) begin
          scan_done_r <= 1'b1;
        end
      end
    end
  end

  // Scan data path: running minimum and maximum.
  always_ff @(posedge clk) begin
    rd_first_r <= (scan_addr_r == '0);
    rd_last_r  <= (scan_addr_r == LAST_IDX);
    rd_vld_r   <= win_vld_r[scan_addr_r];
    if (rd_pend_r) begin
      if (rd_first_r) begin
        lo_r <= scan_val;
        hi_r <= scan_val;
      end else begin
        if (scan_val < lo_r) begin
          lo_r <= scan_val;
        end
        if (scan_val > hi_r) begin
          hi_r <= scan_val;
        end
      end
    end
  end

  // Height, peak hold, fall step and average tracking at the end of a request.
  always_comb begin
    if (div_zero_r) begin
      height = top_w;
    end else if (res_zero_r) begin
      height = '0;
    end else if (quot > {{LW{1'b0}}, top_w}) begin
      height = top_w;
    end else begin
      height = quot[TW-1:0];
    end
    peak_nxt = (height > peak_r) ? height : peak_r;
    fall_inc = fall_cnt_r + vlpt_pkg::FALL_W'(1);
    fall_hit = (fall_inc >= pff_r);
    span     = hi_r - lo_r;
    hi_adj   = ({1'b0, span} < {4'b0000, top_w}) ?
               ({1'b0, lo_r} + {4'b0000, top_w}) : {1'b0, hi_r};
    min_sum  = {1'b0, min_avg_r, 6'b000000} - {7'b0000000, min_avg_r} + {7'b0000000, lo_r};
    max_sum  = {1'b0, max_avg_r, 6'b000000} - {7'b0000000, max_avg_r} + {6'b000000, hi_adj};
  end

  // Architectural state with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= vlpt_pkg::LEVEL_RST;
      min_avg_r   <= vlpt_pkg::MIN_AVG_RST;
      max_avg_r   <= vlpt_pkg::MAX_AVG_RST;
      peak_r      <= vlpt_pkg::PEAK_RST;
      fall_cnt_r  <= '0;
      win_idx_r   <= '0;
      win_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.prep) begin
        level_r              <= level_nxt;
        win_idx_r            <= win_idx_nxt;
        win_vld_r[win_idx_r] <= 1'b1;
      end
      if (cmd.finish) begin
        min_avg_r <= min_sum[15:6];
        max_avg_r <= max_sum[15:6];
        if (fall_hit) begin
          fall_cnt_r <= '0;
          peak_r     <= (peak_nxt != '0) ? (peak_nxt - TW'(1)) : peak_nxt;
        end else begin
          fall_cnt_r <= fall_inc;
          peak_r     <= peak_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mic_r <= in_mic_sample;
    end
    if (cmd.setup) begin
      div_zero_r <= (dd == '0);
      res_zero_r <= lm[LW] ^ dd[LW];
    end
    if (cmd.finish) begin
      bar_r      <= height[vlpt_pkg::HEIGHT_W-1:0];
      peak_out_r <= peak_nxt[vlpt_pkg::HEIGHT_W-1:0];
      vis_r      <= (peak_nxt != '0) && (peak_nxt < {1'b0, colpix_r});
      lvl_out_r  <= level_r;
    end
  end

  always_comb begin
    sts.div_done  = div_done;
    sts.scan_done = scan_done_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_bar_height     = bar_r;
  assign out_peak_height    = peak_out_r;
  assign out_peak_visible   = vis_r;
  assign out_smoothed_level = lvl_out_r;

endmodule

// File: sv/vu_level_peak_tracker_unit.sv
// A request passes from accept through the prep and setup states to the run state,
// which waits for the 17-step divider, the window scan and a free output register.
// One request is in flight at a time; the next request is taken while a result waits.
// Reset (synchronous, active low) restores the configuration, control and tracking
// state and marks every window entry as zero at once; no clearing pass.
`include "assert_macros.svh"

module vu_level_peak_tracker_unit #(
  parameter int WINDOW_LEN = vlpt_pkg::WINDOW_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vlpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vlpt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vlpt_pkg::SAMPLE_W-1:0]  in_mic_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vlpt_pkg::HEIGHT_W-1:0]  out_bar_height,
  output logic [vlpt_pkg::HEIGHT_W-1:0]  out_peak_height,
  output logic                           out_peak_visible,
  output logic [vlpt_pkg::LEVEL_W-1:0]   out_smoothed_level
);

  vlpt_pkg::vlpt_cmd_t cmd;
  vlpt_pkg::vlpt_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  vlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vlpt_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mic_sample      (in_mic_sample),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_bar_height     (out_bar_height),
    .out_peak_height    (out_peak_height),
    .out_peak_visible   (out_peak_visible),
    .out_smoothed_level (out_smoothed_level)
  );

  // Only one request is worked on at a time.
  `VLPT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second request accepted while busy")

  // A result is only written once the divider and the scan have both completed.
  `VLPT_ASSERT(a_finish_ready, clk, rst_n, cmd.finish |-> (sts.div_done && sts.scan_done), "finish before units done")

  // Finishing a request always presents a result on the next cycle.
  `VLPT_ASSERT_NEXT(a_finish_out, clk, rst_n, cmd.finish, out_valid, "result missing after finish")

  // The controller issues at most one command per cycle.
  `VLPT_ASSERT(a_cmd_onehot, clk, rst_n, $onehot0({cmd.load, cmd.prep, cmd.setup, cmd.finish}), "overlapping commands")

endmodule

// File: tb/tb_vu_level_peak_tracker_unit.sv
module tb_vu_level_peak_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import vlpt_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 30;
  localparam int PHASE_ITEMS = 235;

  // One frame of meter output as the block should present it.
  typedef struct {
    logic [HEIGHT_W-1:0] bar;
    logic [HEIGHT_W-1:0] peak;
    logic                visible;
    logic [LEVEL_W-1:0]  level;
  } meter_frame_t;

  // Tracks the meter state and holds the frames still owed by the block.
  class meter_scoreboard;
    int dc_off;
    int floor_lvl;
    int fall_period;
    int col_pix;
    int lvl;
    int min_avg;
    int max_avg;
    int peak;
    int fall_cnt;
    int amp_win[WINDOW_LEN_DEF];
    int win_idx;
    int mismatches;
    meter_frame_t frames_due[$];

    function new();
      dc_off      = 0;
      floor_lvl   = 10;
      fall_period = 15;
      col_pix     = 16;
      lvl         = 2;
      min_avg     = 0;
      max_avg     = 512;
      peak        = 6;
      fall_cnt    = 0;
      foreach (amp_win[i]) amp_win[i] = 0;
      win_idx     = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_DC_OFFSET:     dc_off = int'($signed(d));
        CFG_NOISE_FLOOR:   floor_lvl = int'(d);
        CFG_PEAK_FALL:     fall_period = int'(d);
        CFG_COLUMN_PIXELS: col_pix = int'(d[COLPIX_W-1:0]);
        default: ;
      endcase
    endfunction

    // Advance the meter by one accepted sample and queue the frame it yields.
    function void note_sample(logic [SAMPLE_W-1:0] s);
      int top;
      int amp;
      int h;
      int span;
      int lo;
      int hi;
      meter_frame_t f;
      top = col_pix + 2;
      amp = int'(s) - 512 - dc_off;
      if (amp < 0) amp = -amp;
      amp = (amp <= floor_lvl) ? 0 : amp - floor_lvl;
      lvl = (lvl * 7 + amp) >>> 3;

      // Scale between the tracking averages; equal averages pin the bar to the top.
      span = max_avg - min_avg;
      if (span == 0) h = top;
      else h = (top * (lvl - min_avg)) / span;
      if (h < 0) h = 0;
      else if (h > top) h = top;
      if (h > peak) peak = h;

      f.bar     = h[HEIGHT_W-1:0];
      f.peak    = peak[HEIGHT_W-1:0];
      f.visible = (peak > 0 && peak <= col_pix - 1);
      f.level   = lvl[LEVEL_W-1:0];
      frames_due.push_back(f);

      // Peak hold falls one step per period; a zero period drops it every frame.
      fall_cnt = (fall_cnt + 1) & 255;
      if (fall_cnt >= fall_period) begin
        if (peak > 0) peak--;
        fall_cnt = 0;
      end

      // Window of recent amplitudes sets the targets of the averages.
      amp_win[win_idx] = amp;
      win_idx++;
      if (win_idx >= WINDOW_LEN_DEF) win_idx = 0;
      lo = amp_win[0];
      hi = amp_win[0];
      foreach (amp_win[i]) begin
        if (amp_win[i] < lo) lo = amp_win[i];
        if (amp_win[i] > hi) hi = amp_win[i];
      end
      if (hi - lo < top) hi = lo + top;
      min_avg = (min_avg * 63 + lo) >>> 6;
      max_avg = (max_avg * 63 + hi) >>> 6;
    endfunction

    function void check_frame(meter_frame_t got);
      meter_frame_t want;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: bar %0d peak %0d vis %0d level %0d",
                   got.bar, got.peak, got.visible, got.level);
        return;
      end
      want = frames_due.pop_front();
      if (got.bar !== want.bar || got.peak !== want.peak ||
          got.visible !== want.visible || got.level !== want.level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame mismatch: expected bar %0d peak %0d vis %0d level %0d, got bar %0d peak %0d vis %0d level %0d",
                   want.bar, want.peak, want.visible, want.level,
                   got.bar, got.peak, got.visible, got.level);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_mic_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [HEIGHT_W-1:0]   out_bar_height;
  logic [HEIGHT_W-1:0]   out_peak_height;
  logic                  out_peak_visible;
  logic [LEVEL_W-1:0]    out_smoothed_level;

  meter_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  vu_level_peak_tracker_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mic_sample      (in_mic_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bar_height     (out_bar_height),
    .out_peak_height    (out_peak_height),
    .out_peak_visible   (out_peak_visible),
    .out_smoothed_level (out_smoothed_level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each accepted frame, then pick the next ready level.
  always @(posedge clk) begin
    meter_frame_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.bar     = out_bar_height;
        got.peak    = out_peak_height;
        got.visible = out_peak_visible;
        got.level   = out_smoothed_level;
        sb.check_frame(got);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Write one register; valid is left high so a following write goes straight on.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic set_config(int dc, int nf, int pf, int cp);
    write_reg(CFG_DC_OFFSET, dc[CFG_W-1:0]);
    write_reg(CFG_NOISE_FLOOR, nf[CFG_W-1:0]);
    write_reg(CFG_PEAK_FALL, pf[CFG_W-1:0]);
    write_reg(CFG_COLUMN_PIXELS, cp[CFG_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // Present one sample after a random idle gap and wait for the request to be taken.
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mic_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Stop sending and let every owed frame come out before the block is touched.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 74; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 74; end
      default: begin idle_pct = 27; stall_pct = 27; end
    endcase
  endtask

  // Audio-like stretches: noise, near-silence, symmetric swings and clipped bursts.
  task automatic send_program(int count);
    int sent;
    int style;
    int run;
    int amp;
    logic [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < count) begin
      style = $urandom_range(3);
      run   = $urandom_range(1, 24);
      amp   = $urandom_range(0, 511);
      for (int j = 0; j < run && sent < count; j++) begin
        case (style)
          0: s = SAMPLE_W'($urandom_range(0, 1023));
          1: s = SAMPLE_W'($urandom_range(470, 554));
          2: s = j[0] ? SAMPLE_W'(511 - amp) : SAMPLE_W'(512 + amp);
          default: s = $urandom_range(1) ? SAMPLE_W'($urandom_range(0, 40))
                                         : SAMPLE_W'($urandom_range(983, 1023));
        endcase
        send_sample(s);
        sent++;
      end
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed[];
    int dc;
    int nf;
    int pf;
    int cp;
    directed = {
      10'd0, 10'd1023, 10'd512, 10'd511, 10'd513, 10'd522, 10'd523, 10'd502,
      10'd501, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd512, 10'd512,
      10'd512, 10'd512, 10'd512, 10'd512, 10'd0, 10'd384, 10'd640, 10'd767
    };
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset settings.
    set_idling(0);
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // Phases: the register extremes first, random settings after.
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin dc = -128; nf = 0;   pf = 1;   cp = 1;  end
        1: begin dc = 127;  nf = 255; pf = 255; cp = 63; end
        2: begin dc = 0;    nf = 0;   pf = 0;   cp = 0;  end
        default: begin
          dc = int'($urandom_range(0, 255)) - 128;
          nf = $urandom_range(3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 40);
          pf = $urandom_range(0, 255);
          cp = $urandom_range(0, 63);
        end
      endcase
      set_config(dc, nf, pf, cp);
      set_idling(k % 4);
      send_program(PHASE_ITEMS);
      drain();
    end

    if (sb.mismatches == 0 && sb.frames_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
